@@ design/ljqs_pkg.sv @@
// Shared types and constants of the lane job queue scheduler.
package ljqs_pkg;
	localparam int NUM_LANES   = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int LW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int AW = LW + SW;
	localparam int NSLOT = NUM_LANES * QUEUE_DEPTH;

	localparam logic [2:0] CMD_ENQ     = 3'd0;
	localparam logic [2:0] CMD_EVENT   = 3'd1;
	localparam logic [2:0] CMD_DONE    = 3'd2;
	localparam logic [2:0] CMD_PAUSE   = 3'd4;
	localparam logic [2:0] CMD_RESUME  = 3'd5;
	localparam logic [2:0] CMD_UNBLOCK = 3'd6;

	localparam logic [3:0] EV_ONLINE   = 4'd0;
	localparam logic [3:0] EV_OFFLINE  = 4'd1;
	localparam logic [3:0] EV_COVER_O  = 4'd2;
	localparam logic [3:0] EV_COVER_C  = 4'd3;
	localparam logic [3:0] EV_PAPER_O  = 4'd4;
	localparam logic [3:0] EV_PAPER_NE = 4'd5;
	localparam logic [3:0] EV_PAPER_OK = 4'd6;
	localparam logic [3:0] EV_LINK_L   = 4'd7;
	localparam logic [3:0] EV_LINK_R   = 4'd8;

	localparam logic [1:0] K_HELD    = 2'd0;
	localparam logic [1:0] K_STARTED = 2'd1;
	localparam logic [1:0] K_OVF     = 2'd2;
	localparam logic [1:0] K_EXP     = 2'd3;

	localparam logic [1:0] REG_HOLD = 2'd0;
	localparam logic [1:0] REG_PRIO = 2'd1;
	localparam logic [1:0] REG_MAXD = 2'd2;
	localparam logic [1:0] REG_TTL  = 2'd3;

	// packed slot entry: job, prio, order, deadline-present, deadline
	localparam int EW = 16 + 8 + 32 + 1 + 32;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  lane;
		logic [15:0] job_tag;
		logic [7:0]  priority_req;
		logic [30:0] ttl_ms;
		logic [3:0]  event_code;
		logic        outcome_unknown;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        hold;
		logic        by_prio;
		logic [3:0]  depth_lim;
		logic [30:0] ttl;
	} cfg_t;
endpackage

@@ design/ljqs_ram.sv @@
// Generic single-port-write RAM with registered read.
module ljqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/ljqs_front.sv @@
// Front end: accepts commands into a short queue.
module ljqs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ljqs_pkg::item_t push_item,
	input  logic           pop,
	output logic           empty,
	output logic           full,
	output ljqs_pkg::item_t head
);
	import ljqs_pkg::*;
	item_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ design/ljqs_back.sv @@
// Back end: command execution, slot store and the per-lane pump sequencer.
module ljqs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ljqs_pkg::cfg_t  cfg,
	input  logic            empty,
	input  ljqs_pkg::item_t head,
	output logic            pop,
	output logic            res_valid,
	output logic [1:0]      kind,
	output logic [1:0]      out_lane,
	output logic [15:0]     out_job,
	output logic [31:0]     expired_total,
	output logic [31:0]     overflow_total,
	output logic [31:0]     started_total,
	output logic            last
);
	import ljqs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CMD, S_RD, S_CHK, S_EXP, S_START, S_NEXT
	} state_t;
	state_t state_q;

	logic [6:0] flags_q [NUM_LANES];
	logic [NSLOT-1:0] valid_q;
	logic [31:0] arr_q;
	item_t it_q;
	logic [LW-1:0] ln_q;
	logic [SW:0] k_q;
	logic found_q, bprio_q, pend_q;
	logic [SW-1:0] best_q;
	logic [7:0] bp_q;
	logic [31:0] ba_q;
	logic [15:0] bj_q;
	logic [1:0] p_kind_q, p_lane_q;
	logic [15:0] p_job_q;
	logic [31:0] cnt_exp_q, cnt_ovf_q, cnt_start_q;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [EW-1:0] ram_wd, ram_rd;

	ljqs_ram #(.WIDTH(EW), .DEPTH(NSLOT)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [15:0] e_job;
	logic [7:0]  e_prio;
	logic [31:0] e_ord, e_dl, e_age;
	logic        e_has;
	assign {e_job, e_prio, e_ord, e_has, e_dl} = ram_rd;
	assign e_age = arr_q - e_ord;

	// lane view of valid bits
	logic [QUEUE_DEPTH-1:0] lv, cv;
	logic [LW-1:0] cl;
	assign cl = it_q.lane[LW-1:0];
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			lv[i] = valid_q[AW'(ln_q)*AW'(QUEUE_DEPTH) + AW'(i)];
			cv[i] = valid_q[AW'(cl)*AW'(QUEUE_DEPTH) + AW'(i)];
		end
	end

	function automatic logic drn(input logic [6:0] f, input logic hold);
		return !(|f[6:4]) && (!hold || f[3:0] == 4'd0);
	endfunction

	// enqueue classification
	logic [SW:0] held;
	logic [SW-1:0] fslot;
	logic ffound, lane_ok, ovf;
	logic [30:0] ttl_eff;
	assign lane_ok = ({30'd0, it_q.lane} < 32'(NUM_LANES));
	always_comb begin
		held = '0; fslot = '0; ffound = 1'b0;
		for (int i = QUEUE_DEPTH-1; i >= 0; i--) begin
			if (cv[i]) held = held + 1'b1;
			else begin
				ffound = 1'b1;
				fslot = SW'(i);
			end
		end
		ovf = (cfg.depth_lim != 4'd0 && 32'(held) >= 32'(cfg.depth_lim)) || !ffound;
		ttl_eff = (it_q.ttl_ms == 31'd0) ? cfg.ttl : it_q.ttl_ms;
	end

	logic exp_hit, cand_better;
	logic [31:0] dt;
	assign dt = it_q.now_ms - e_dl;
	assign exp_hit = e_has && !dt[31];
	always_comb begin
		if (!found_q) cand_better = 1'b1;
		else if (cfg.by_prio && e_prio != bp_q)
			cand_better = $signed(e_prio) > $signed(bp_q);
		else cand_better = e_age > ba_q;
	end

	logic [SW-1:0] kk;
	assign kk = k_q[SW-1:0];
	assign ram_ra = AW'(ln_q) * AW'(QUEUE_DEPTH) + AW'(kk);
	assign pop = (state_q == S_IDLE) && !empty;

	logic last_lane;
	assign last_lane = (32'(ln_q) == 32'(NUM_LANES-1));

	always_comb begin
		ram_we = (state_q == S_CMD) && lane_ok && it_q.command == CMD_ENQ &&
			!drn(flags_q[cl], cfg.hold) && !ovf;
		ram_wa = AW'(cl) * AW'(QUEUE_DEPTH) + AW'(fslot);
		ram_wd = {it_q.job_tag, it_q.priority_req, arr_q, (ttl_eff != 31'd0),
			it_q.now_ms + {1'b0, ttl_eff}};
	end

	// a result waits in the p_ registers until the next one is known,
	// so the final one of a command can carry last
	logic new_res, fin, flush;
	assign new_res = (state_q == S_CMD && lane_ok && it_q.command == CMD_ENQ) ||
		((state_q == S_EXP || state_q == S_START) && found_q);
	assign fin = (state_q == S_NEXT) && last_lane;
	assign flush = pend_q && (new_res || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_LANES; i++) flags_q[i] <= '0;
			valid_q <= '0;
			arr_q <= '0;
			it_q <= '0;
			expired_total <= '0;
			overflow_total <= '0;
			started_total <= '0;
			cnt_exp_q <= '0; cnt_ovf_q <= '0; cnt_start_q <= '0;
			res_valid <= 1'b0;
			pend_q <= 1'b0;
			kind <= '0; out_lane <= '0; out_job <= '0; last <= 1'b0;
			p_kind_q <= '0; p_lane_q <= '0; p_job_q <= '0;
			ln_q <= '0; k_q <= '0; found_q <= 1'b0; bprio_q <= 1'b0;
			best_q <= '0; bp_q <= '0; ba_q <= '0; bj_q <= '0;
		end else begin
			case (state_q)
			S_IDLE: begin
				if (!empty) begin
					it_q <= head;
					state_q <= S_CMD;
				end
			end
			S_CMD: begin
				ln_q <= '0;
				k_q <= '0;
				found_q <= 1'b0;
				bprio_q <= 1'b0;
				state_q <= S_RD;
				if (lane_ok) begin
					case (it_q.command)
					CMD_ENQ: begin
						p_lane_q <= it_q.lane;
						p_job_q <= it_q.job_tag;
						if (drn(flags_q[cl], cfg.hold)) begin
							flags_q[cl][6] <= 1'b1;
							cnt_start_q <= cnt_start_q + 32'd1;
							p_kind_q <= K_STARTED;
						end else if (ram_we) begin
							valid_q[AW'(cl)*AW'(QUEUE_DEPTH) + AW'(fslot)] <= 1'b1;
							arr_q <= arr_q + 32'd1;
							p_kind_q <= K_HELD;
						end else begin
							cnt_ovf_q <= cnt_ovf_q + 32'd1;
							p_kind_q <= K_OVF;
						end
					end
					CMD_EVENT: begin
						case (it_q.event_code)
						EV_ONLINE: flags_q[cl][0] <= 1'b0;
						EV_OFFLINE: flags_q[cl][0] <= 1'b1;
						EV_COVER_O: flags_q[cl][1] <= 1'b1;
						EV_COVER_C: flags_q[cl][1] <= 1'b0;
						EV_PAPER_O: flags_q[cl][2] <= 1'b1;
						EV_PAPER_NE, EV_PAPER_OK: flags_q[cl][2] <= 1'b0;
						EV_LINK_L: flags_q[cl][3] <= 1'b1;
						EV_LINK_R: flags_q[cl][3] <= 1'b0;
						default: ;
						endcase
					end
					CMD_DONE: begin
						flags_q[cl][6] <= 1'b0;
						if (it_q.outcome_unknown) flags_q[cl][4] <= 1'b1;
					end
					CMD_PAUSE: flags_q[cl][5] <= 1'b1;
					CMD_RESUME: flags_q[cl][5] <= 1'b0;
					CMD_UNBLOCK: flags_q[cl][4] <= 1'b0;
					default: ;
					endcase
				end
			end
			S_RD: begin
				// read address issued; scan data arrives next cycle
				state_q <= S_CHK;
			end
			S_CHK: begin
				// expiry scan (bprio_q=0) picks oldest expired; start scan picks best
				if (lv[kk] && (bprio_q ? 1'b1 : exp_hit) &&
					(bprio_q ? cand_better : (!found_q || e_age > ba_q))) begin
					found_q <= 1'b1;
					best_q <= kk;
					bp_q <= e_prio;
					ba_q <= e_age;
					bj_q <= e_job;
				end
				if (k_q == (SW+1)'(QUEUE_DEPTH-1)) begin
					k_q <= '0;
					state_q <= bprio_q ? S_START : S_EXP;
				end else begin
					k_q <= k_q + 1'b1;
					state_q <= S_RD;
				end
			end
			S_EXP: begin
				found_q <= 1'b0;
				if (found_q) begin
					valid_q[AW'(ln_q)*AW'(QUEUE_DEPTH) + AW'(best_q)] <= 1'b0;
					p_kind_q <= K_EXP; p_lane_q <= 2'(ln_q); p_job_q <= bj_q;
					cnt_exp_q <= cnt_exp_q + 32'd1;
					state_q <= S_RD;
				end else if (drn(flags_q[ln_q], cfg.hold)) begin
					bprio_q <= 1'b1;
					state_q <= S_RD;
				end else state_q <= S_NEXT;
			end
			S_START: begin
				found_q <= 1'b0;
				bprio_q <= 1'b0;
				if (found_q) begin
					valid_q[AW'(ln_q)*AW'(QUEUE_DEPTH) + AW'(best_q)] <= 1'b0;
					flags_q[ln_q][6] <= 1'b1;
					p_kind_q <= K_STARTED; p_lane_q <= 2'(ln_q); p_job_q <= bj_q;
					cnt_start_q <= cnt_start_q + 32'd1;
				end
				state_q <= S_NEXT;
			end
			S_NEXT: begin
				if (last_lane) begin
					state_q <= S_IDLE;
				end else begin
					ln_q <= ln_q + 1'b1;
					state_q <= S_RD;
				end
			end
			default: state_q <= S_IDLE;
			endcase

			// the counters have not moved since the waiting result was made
			res_valid <= flush;
			if (flush) begin
				kind <= p_kind_q;
				out_lane <= p_lane_q;
				out_job <= p_job_q;
				expired_total <= cnt_exp_q;
				overflow_total <= cnt_ovf_q;
				started_total <= cnt_start_q;
				last <= fin;
			end
			if (fin) pend_q <= 1'b0;
			else if (new_res) pend_q <= 1'b1;
		end
	end
endmodule

@@ design/lane_job_queue_scheduler_unit.sv @@
// Top level of the lane job queue scheduler.
// Commands enter on start/busy: one is accepted at a clock edge with start high
// and busy low. The front end parks it in a two-entry queue; busy is high while
// both entries are taken. The back end applies the command to the lane flags or
// slot store, then pumps every lane in order. Per lane the pump scans the
// QUEUE_DEPTH slots of the slot RAM (one read port; each slot is read in S_RD
// and checked in S_CHK) for the oldest expired job, repeating after each
// expiry, then on a drainable lane scans once more to pick a job to start.
// The back end takes a new item only after the pump for the last has ended.
// Results appear on kind/out_lane/out_job and the totals for one cycle each,
// marked by done; each waits until the next is known so that last can mark the
// final one, which leaves the cycle after the pump ends. The receiver cannot
// stall. Reset clears flags, valid bits and counters; configuration resets to
// hold on, the rest zero. Slot contents are written before they are read.
// Configuration is an APB slave at byte addresses 0,4,8,12.
module lane_job_queue_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [1:0]  lane,
	input  logic [15:0] job_tag,
	input  logic signed [7:0] priority_req,
	input  logic [30:0] ttl_ms,
	input  logic [3:0]  event_code,
	input  logic        outcome_unknown,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [1:0]  kind,
	output logic [1:0]  out_lane,
	output logic [15:0] out_job,
	output logic [31:0] expired_total,
	output logic [31:0] overflow_total,
	output logic [31:0] started_total,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ljqs_pkg::*;
	cfg_t cfg_q;
	item_t in_item, head;
	logic empty, full, pop;
	logic [1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[3:2];
	assign busy = full;
	assign in_item = {command, lane, job_tag, priority_req, ttl_ms, event_code,
		outcome_unknown, now_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{hold: 1'b1, by_prio: 1'b0, depth_lim: 4'd0, ttl: 31'd0};
		end else if (psel && penable && pwrite) begin
			case (ridx)
			REG_HOLD: cfg_q.hold <= pwdata[0];
			REG_PRIO: cfg_q.by_prio <= pwdata[0];
			REG_MAXD: cfg_q.depth_lim <= pwdata[3:0];
			REG_TTL: cfg_q.ttl <= pwdata[30:0];
			default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
		REG_HOLD: prdata = {31'd0, cfg_q.hold};
		REG_PRIO: prdata = {31'd0, cfg_q.by_prio};
		REG_MAXD: prdata = {28'd0, cfg_q.depth_lim};
		REG_TTL: prdata = {1'b0, cfg_q.ttl};
		default: prdata = '0;
		endcase
	end

	ljqs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(start && !full), .push_item(in_item),
		.pop(pop), .empty(empty), .full(full), .head(head)
	);

	ljqs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .empty(empty), .head(head),
		.pop(pop), .res_valid(done), .kind(kind), .out_lane(out_lane),
		.out_job(out_job), .expired_total(expired_total),
		.overflow_total(overflow_total), .started_total(started_total), .last(last)
	);
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for lane_job_queue_scheduler_unit: predicts every result and compares.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ljqs_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 1000;
	localparam logic [2:0] CMD_TICK  = 3'd3;
	localparam logic [2:0] CMD_SPARE = 3'd7;

	typedef struct {
		logic [1:0]  kind;
		logic [1:0]  lane;
		logic [15:0] job;
		logic [31:0] n_exp;
		logic [31:0] n_ovf;
		logic [31:0] n_start;
		logic        last;
	} sched_res_t;

	logic clk, arst_n, start, busy, done, last, pready;
	logic [2:0] command;
	logic [1:0] lane, kind, out_lane;
	logic [15:0] job_tag, out_job;
	logic signed [7:0] priority_req;
	logic [30:0] ttl_ms;
	logic [3:0] event_code, paddr;
	logic outcome_unknown, psel, penable, pwrite;
	logic [31:0] now_ms, expired_total, overflow_total, started_total, pwdata, prdata;

	lane_job_queue_scheduler_unit dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// scheduler state as predicted
	cfg_t        cfg;
	logic [6:0]  lane_st [NUM_LANES];
	logic        slot_busy [NSLOT];
	logic [15:0] slot_tag [NSLOT];
	logic signed [7:0] slot_pri [NSLOT];
	logic [31:0] slot_seq [NSLOT];
	logic        slot_has_dl [NSLOT];
	logic [31:0] slot_dl [NSLOT];
	logic [31:0] arrivals, cnt_exp, cnt_ovf, cnt_start;

	item_t       job_q [$];
	sched_res_t  due_q [$];
	sched_res_t  step_res [$];
	item_t       drv_item;
	int          gap_left, burst_left, accepted, checked, mismatches, idle_cycles;
	logic [31:0] now_t;
	logic        apb_xfer;

	function automatic logic can_drain(int ln);
		if (lane_st[ln][6:4] != 3'b000)
			return 1'b0;
		return !cfg.hold || lane_st[ln][3:0] == 4'b0000;
	endfunction

	function automatic void note(logic [1:0] k, int ln, logic [15:0] tag);
		sched_res_t r;
		r.kind = k; r.lane = ln[1:0]; r.job = tag;
		r.n_exp = cnt_exp; r.n_ovf = cnt_ovf; r.n_start = cnt_start; r.last = 1'b0;
		step_res = {step_res, r};
	endfunction

	function automatic logic timed_out(int s, logic [31:0] now);
		logic [31:0] d;
		d = now - slot_dl[s];
		return slot_has_dl[s] && !d[31];
	endfunction

	function automatic void run_pump(logic [31:0] now);
		int best, s;
		for (int ln = 0; ln < NUM_LANES; ln++) begin
			forever begin
				best = -1;
				for (int k = 0; k < QUEUE_DEPTH; k++) begin
					s = ln * QUEUE_DEPTH + k;
					if (slot_busy[s] && timed_out(s, now) && (best < 0 ||
					    arrivals - slot_seq[s] > arrivals - slot_seq[best]))
						best = s;
				end
				if (best < 0)
					break;
				slot_busy[best] = 1'b0;
				cnt_exp++;
				note(K_EXP, ln, slot_tag[best]);
			end
			if (!can_drain(ln))
				continue;
			best = -1;
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				s = ln * QUEUE_DEPTH + k;
				if (!slot_busy[s])
					continue;
				if (best < 0) begin
					best = s;
					continue;
				end
				if (cfg.by_prio && slot_pri[s] != slot_pri[best]) begin
					if (slot_pri[s] > slot_pri[best])
						best = s;
					continue;
				end
				if (arrivals - slot_seq[s] > arrivals - slot_seq[best])
					best = s;
			end
			if (best >= 0) begin
				slot_busy[best] = 1'b0;
				lane_st[ln][6] = 1'b1;
				cnt_start++;
				note(K_STARTED, ln, slot_tag[best]);
			end
		end
	endfunction

	function automatic void place_job(item_t it);
		int ln, held, free_s;
		logic [30:0] life;
		ln = it.lane;
		if (can_drain(ln)) begin
			lane_st[ln][6] = 1'b1;
			cnt_start++;
			note(K_STARTED, ln, it.job_tag);
			return;
		end
		held = 0; free_s = -1;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			if (slot_busy[ln * QUEUE_DEPTH + k])
				held++;
			else if (free_s < 0)
				free_s = ln * QUEUE_DEPTH + k;
		end
		if ((cfg.depth_lim != 0 && held >= cfg.depth_lim) || free_s < 0) begin
			cnt_ovf++;
			note(K_OVF, ln, it.job_tag);
			return;
		end
		life = (it.ttl_ms == 0) ? cfg.ttl : it.ttl_ms;
		slot_busy[free_s] = 1'b1;
		slot_tag[free_s] = it.job_tag;
		slot_pri[free_s] = it.priority_req;
		slot_seq[free_s] = arrivals++;
		slot_has_dl[free_s] = (life != 0);
		slot_dl[free_s] = it.now_ms + {1'b0, life};
		note(K_HELD, ln, it.job_tag);
	endfunction

	function automatic void predict_step(item_t it);
		int ln;
		ln = it.lane;
		step_res.delete();
		if (ln < NUM_LANES) begin
			case (it.command)
				CMD_ENQ: place_job(it);
				CMD_EVENT: begin
					case (it.event_code)
						EV_ONLINE:   lane_st[ln][0] = 1'b0;
						EV_OFFLINE:  lane_st[ln][0] = 1'b1;
						EV_COVER_O:  lane_st[ln][1] = 1'b1;
						EV_COVER_C:  lane_st[ln][1] = 1'b0;
						EV_PAPER_O:  lane_st[ln][2] = 1'b1;
						EV_PAPER_NE,
						EV_PAPER_OK: lane_st[ln][2] = 1'b0;
						EV_LINK_L:   lane_st[ln][3] = 1'b1;
						EV_LINK_R:   lane_st[ln][3] = 1'b0;
						default: ;
					endcase
				end
				CMD_DONE: begin
					lane_st[ln][6] = 1'b0;
					if (it.outcome_unknown)
						lane_st[ln][4] = 1'b1;
				end
				CMD_PAUSE:   lane_st[ln][5] = 1'b1;
				CMD_RESUME:  lane_st[ln][5] = 1'b0;
				CMD_UNBLOCK: lane_st[ln][4] = 1'b0;
				default: ;
			endcase
		end
		run_pump(it.now_ms);
		if (step_res.size() > 0)
			step_res[$].last = 1'b1;
		due_q = {due_q, step_res};
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= '0; lane <= '0; job_tag <= '0; priority_req <= '0;
			ttl_ms <= '0; event_code <= '0; outcome_unknown <= 1'b0; now_ms <= '0;
			gap_left <= 0;
			burst_left <= 1;
		end else begin
			if (start && !busy) begin
				predict_step(drv_item);
				accepted++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (job_q.size() > 0) begin
				drv_item = job_q.pop_front();
				command <= drv_item.command; lane <= drv_item.lane;
				job_tag <= drv_item.job_tag; priority_req <= drv_item.priority_req;
				ttl_ms <= drv_item.ttl_ms; event_code <= drv_item.event_code;
				outcome_unknown <= drv_item.outcome_unknown; now_ms <= drv_item.now_ms;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: kind %0d lane %0d job %h",
					         kind, out_lane, out_job);
			end else begin
				sched_res_t e;
				e = due_q.pop_front();
				checked++;
				if (kind !== e.kind || out_lane !== e.lane || out_job !== e.job ||
				    expired_total !== e.n_exp || overflow_total !== e.n_ovf ||
				    started_total !== e.n_start || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp kind %0d lane %0d job %h tot %0d/%0d/%0d last %b",
						         e.kind, e.lane, e.job, e.n_exp, e.n_ovf, e.n_start, e.last);
						$display("          got kind %0d lane %0d job %h tot %0d/%0d/%0d last %b",
						         kind, out_lane, out_job, expired_total, overflow_total,
						         started_total, last);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || apb_xfer) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results still due", due_q.size());
			$display("** lane_job_queue_scheduler_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic add_item(logic [2:0] c, logic [1:0] ln, logic [15:0] tag,
	                        logic [7:0] pri, logic [30:0] life, logic [3:0] ev,
	                        logic unk, logic [31:0] now);
		item_t it;
		it.command = c; it.lane = ln; it.job_tag = tag; it.priority_req = pri;
		it.ttl_ms = life; it.event_code = ev; it.outcome_unknown = unk; it.now_ms = now;
		job_q = {job_q, it};
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		apb_xfer <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		apb_xfer <= 1'b0;
		case (idx)
			REG_HOLD: cfg.hold = val[0];
			REG_PRIO: cfg.by_prio = val[0];
			REG_MAXD: cfg.depth_lim = val[3:0];
			REG_TTL:  cfg.ttl = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic h, logic p, logic [3:0] md, logic [30:0] life);
		reg_write(REG_HOLD, {31'd0, h});
		reg_write(REG_PRIO, {31'd0, p});
		reg_write(REG_MAXD, {28'd0, md});
		reg_write(REG_TTL, {1'b0, life});
	endtask

	task automatic wait_quiet();
		while (job_q.size() > 0 || start || due_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random(int n);
		int pick;
		logic [30:0] life;
		logic [2:0] c;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)      c = CMD_ENQ;
			else if (pick < 58) c = CMD_DONE;
			else if (pick < 70) c = CMD_EVENT;
			else if (pick < 78) c = CMD_TICK;
			else if (pick < 84) c = CMD_PAUSE;
			else if (pick < 90) c = CMD_RESUME;
			else if (pick < 96) c = CMD_UNBLOCK;
			else                c = CMD_SPARE;
			case ($urandom_range(0, 9))
				0, 1, 2: life = '0;
				3, 4, 5, 6: life = 31'($urandom_range(1, 200));
				default: life = 31'($urandom());
			endcase
			case ($urandom_range(0, 19))
				0: now_t = now_t + 32'h7FFF_0000 + $urandom_range(0, 32'h2_0000);
				1: now_t = $urandom();
				default: now_t = now_t + $urandom_range(0, 60);
			endcase
			add_item(c, 2'($urandom_range(0, 3)), 16'($urandom()), 8'($urandom()), life,
			         4'($urandom_range(0, 15)), ($urandom_range(0, 5) == 0), now_t);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		apb_xfer = 1'b0;
		cfg = '{hold: 1'b1, by_prio: 1'b0, depth_lim: 4'd0, ttl: 31'd0};
		for (int l = 0; l < NUM_LANES; l++)
			lane_st[l] = '0;
		for (int s = 0; s < NSLOT; s++)
			slot_busy[s] = 1'b0;
		arrivals = 0; cnt_exp = 0; cnt_ovf = 0; cnt_start = 0;
		accepted = 0; checked = 0; mismatches = 0;
		now_t = 32'hFFFF_FF00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset configuration, extremes, every command and event
		add_item(CMD_ENQ, 2'd0, 16'h0000, 8'h80, 31'h7FFF_FFFF, 4'd0, 1'b0, now_t);
		add_item(CMD_ENQ, 2'd0, 16'hFFFF, 8'h7F, 31'd10, 4'd0, 1'b0, now_t);
		add_item(CMD_ENQ, 2'd0, 16'h1234, 8'h80, 31'd0, 4'd0, 1'b0, now_t);
		add_item(CMD_TICK, 2'd0, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd300);
		add_item(CMD_DONE, 2'd0, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd301);
		for (int e = 0; e < 12; e++)
			add_item(CMD_EVENT, 2'd1, 16'd0, 8'd0, 31'd0, e[3:0], 1'b0, now_t + 32'd302);
		add_item(CMD_ENQ, 2'd1, 16'hA5A5, 8'h01, 31'd5, 4'd0, 1'b0, now_t + 32'd303);
		add_item(CMD_EVENT, 2'd1, 16'd0, 8'd0, 31'd0, EV_PAPER_NE, 1'b0, now_t + 32'd304);
		add_item(CMD_DONE, 2'd2, 16'd0, 8'd0, 31'd0, 4'd0, 1'b1, now_t + 32'd305);
		add_item(CMD_PAUSE, 2'd3, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd306);
		add_item(CMD_ENQ, 2'd3, 16'h5A5A, 8'hFF, 31'd0, 4'd0, 1'b0, now_t + 32'd307);
		add_item(CMD_RESUME, 2'd3, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd308);
		add_item(CMD_UNBLOCK, 2'd2, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd309);
		add_item(CMD_SPARE, 2'd0, 16'd0, 8'd0, 31'd0, 4'd0, 1'b0, now_t + 32'd310);
		now_t = now_t + 32'd400;
		wait_quiet();

		set_config(1'b0, 1'b1, 4'd8, 31'h7FFF_FFFF);
		add_random(20);
		wait_quiet();
		set_config(1'b1, 1'b1, 4'd1, 31'd100);
		add_random(20);
		wait_quiet();
		set_config(1'b0, 1'b0, 4'd3, 31'd5);
		add_random(20);
		wait_quiet();
		set_config(1'b0, 1'b1, 4'd0, 31'd0);
		add_random(20);
		wait_quiet();

		$display("%0d commands sent over five register settings, %0d results checked",
		         accepted, checked);
		$display("totals seen: %0d started, %0d overflowed, %0d expired",
		         cnt_start, cnt_ovf, cnt_exp);
		if (mismatches == 0 && due_q.size() == 0) begin
			$display("** lane_job_queue_scheduler_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, due_q.size());
			$display("** lane_job_queue_scheduler_unit: FAILED **");
		end
		$finish;
	end
endmodule
